### rtl/odrm_pkg.sv
`default_nettype none

package odrm_pkg;

   localparam int PIX_W        = 8;
   localparam int SIZE_W       = 3;
   localparam int LEVELS_W     = 9;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 9;
   localparam int PHASE_W      = 3;
   localparam int PROD_W       = 17;
   localparam int Q_W          = 9;
   localparam int X_W          = 17;
   localparam int REM_W        = 8;
   localparam int THR_W        = 15;
   localparam int NSQ_W        = 7;
   localparam int ENTRY_W      = 6;
   localparam int LANE_STAGES  = 5;
   localparam int PIPE_STAGES  = 6;
   localparam int CTL_STAGES   = 3;

   // floor(p/255) = (p * ceil(2^25/255)) >> 25, exact for p below 2^17
   localparam int DIV255_SHIFT = 25;
   localparam int DIV255_W     = 35;
   localparam logic [DIV255_W-1:0] DIV255_MUL = 35'd131587;

   // floor(x/d) = (x * ceil(2^26/d)) >> 26, exact for x below 2^17, d up to 510
   localparam int RECIP_SHIFT  = 26;
   localparam int RECIP_W      = 27;
   localparam int RECIP_CNT_W  = 5;
   localparam int MUL_W        = 44;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATRIX_SIZE = 1'b0,
      CSR_LEVELS      = 1'b1
   } odrm_csr_type;

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } odrm_div_state_type;

   // per-pixel rounding threshold, shared by all three lanes
   typedef struct packed {
      logic [THR_W-1:0] thr;
      logic [NSQ_W-1:0] nsq2;
   } odrm_ctl_type;

   localparam logic [ENTRY_W-1:0] MAT2 [4]  = '{6'd0, 6'd2, 6'd3, 6'd1};
   localparam logic [ENTRY_W-1:0] MAT3 [9]  = '{6'd6, 6'd8, 6'd4, 6'd1, 6'd0, 6'd3,
                                                 6'd5, 6'd2, 6'd7};
   localparam logic [ENTRY_W-1:0] MAT4 [16] = '{6'd0,  6'd8,  6'd2,  6'd10,
                                                 6'd12, 6'd4,  6'd14, 6'd6,
                                                 6'd3,  6'd11, 6'd1,  6'd9,
                                                 6'd15, 6'd7,  6'd13, 6'd5};
   localparam logic [ENTRY_W-1:0] MAT6 [36] = '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34,
                                                 6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18,
                                                 6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46,
                                                 6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30,
                                                 6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33,
                                                 6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17};

   // unsupported sizes fall back to 2
   function automatic logic [SIZE_W-1:0] odrm_side(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] n;
      n = 3'd2;
      if (size == 3'd3 || size == 3'd4 || size == 3'd6) begin
         n = size;
      end
      return n;
   endfunction

   function automatic logic [PHASE_W-1:0] odrm_wrap(input logic [PHASE_W-1:0] val,
                                                    input logic [SIZE_W-1:0]  n);
      logic [PHASE_W-1:0] v;
      v = val;
      for (int i = 0; i < 3; i++) begin
         if (v >= n) begin
            v = v - n;
         end
      end
      return v;
   endfunction

   function automatic logic [ENTRY_W-1:0] odrm_entry(input logic [SIZE_W-1:0]  n,
                                                     input logic [PHASE_W-1:0] row,
                                                     input logic [PHASE_W-1:0] col);
      logic [3:0]         k3;
      logic [5:0]         k6;
      logic [ENTRY_W-1:0] t;
      k3 = 4'(row) * 4'd3 + 4'(col);
      k6 = 6'(row) * 6'd6 + 6'(col);
      unique case (n)
         3'd3:    t = MAT3[k3];
         3'd4:    t = MAT4[{row[1:0], col[1:0]}];
         3'd6:    t = MAT6[k6];
         default: t = MAT2[{row[0], col[0]}];
      endcase
      return t;
   endfunction

   function automatic logic [NSQ_W-1:0] odrm_nsq2(input logic [SIZE_W-1:0] n);
      logic [NSQ_W-1:0] s;
      unique case (n)
         3'd3:    s = 7'd18;
         3'd4:    s = 7'd32;
         3'd6:    s = 7'd72;
         default: s = 7'd8;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

### rtl/odrm_if.sv
`default_nettype none

interface odrm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic       frame_start;
   logic       line_end;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   output frame_start, output line_end, input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   input frame_start, input line_end, output ready);
endinterface

interface odrm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

`default_nettype wire

### rtl/odrm_recip.sv
`default_nettype none

// serial divider: recip = ceil(2^26 / divisor), one quotient bit a cycle
module odrm_recip
   import odrm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [LEVELS_W-1:0]  divisor,
   output logic                      busy,
   output logic [RECIP_W-1:0]        recip
);

   odrm_div_state_type state_ff, state_in;
   logic [RECIP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEVELS_W-1:0]    rem_ff, rem_in;
   logic [RECIP_W-1:0]     quo_ff, quo_in;

   logic [RECIP_W-1:0]     numer;
   logic [LEVELS_W:0]      trial;
   logic                   qbit;
   logic                   last;

   // adding d-1 turns the floor into a ceiling
   assign numer = (RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(divisor) - RECIP_W'(1);
   assign trial = {rem_ff, numer[cnt_ff]};
   assign qbit  = (trial >= (LEVELS_W+1)'(divisor));
   assign last  = (cnt_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (start) state_in = DIV_RUN;
         DIV_RUN:  if (last && !start) state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               cnt_in = RECIP_CNT_W'(RECIP_W - 1);
               rem_in = '0;
               quo_in = '0;
            end
         end
         DIV_RUN: begin
            // a fresh start during a run begins again with the new divisor
            if (start) begin
               cnt_in = RECIP_CNT_W'(RECIP_W - 1);
               rem_in = '0;
               quo_in = '0;
            end else begin
               rem_in = qbit ? LEVELS_W'(trial - (LEVELS_W+1)'(divisor))
                             : trial[LEVELS_W-1:0];
               quo_in = {quo_ff[RECIP_W-2:0], qbit};
               cnt_in = cnt_ff - RECIP_CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy  = start || (state_ff == DIV_RUN);
   assign recip = quo_ff;

endmodule

`default_nettype wire

### rtl/odrm_lane.sv
`default_nettype none

// one colour channel: quantize, round against the threshold, clamp, rescale
module odrm_lane
   import odrm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [LANE_STAGES-1:0]  load,
   input  wire logic [PIX_W-1:0]        value,
   input  wire logic [LEVELS_W-1:0]     lv,
   input  wire logic [LEVELS_W-1:0]     top_level,
   input  wire logic [RECIP_W-1:0]      recip,
   input  wire odrm_ctl_type            ctl,
   output logic      [MUL_W-1:0]        scaled
);

   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W-1:0]   prod2_ff;
   logic [Q_W-1:0]      q0_ff, q0_in;
   logic [Q_W-1:0]      q0b_ff;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [X_W-1:0]      x_ff, x_in;
   logic [MUL_W-1:0]    mul_ff, mul_in;

   logic [DIV255_W-1:0] q0_full;
   logic [PROD_W-1:0]   q0_x255;
   logic [PROD_W-1:0]   diff;
   logic [THR_W-1:0]    frac;
   logic                round_up;
   logic [Q_W:0]        qsum;
   logic [Q_W-1:0]      qcl;

   assign prod_in = PROD_W'(value) * PROD_W'(lv);

   assign q0_full = DIV255_W'(prod_ff) * DIV255_MUL;
   assign q0_in   = q0_full[DIV255_SHIFT +: Q_W];

   assign q0_x255 = (PROD_W'(q0_ff) << 8) - PROD_W'(q0_ff);
   assign diff    = prod2_ff - q0_x255;
   assign rem_in  = diff[REM_W-1:0];

   // remainder scaled by 2*N*N against 255*(2t+1)
   assign frac     = THR_W'(rem_ff) * THR_W'(ctl.nsq2);
   assign round_up = (frac > ctl.thr);
   assign qsum     = (Q_W+1)'(q0b_ff) + (Q_W+1)'(round_up);
   assign qcl      = (qsum > (Q_W+1)'(top_level)) ? top_level : qsum[Q_W-1:0];
   assign x_in     = (X_W'(qcl) << 8) - X_W'(qcl);

   assign mul_in = MUL_W'(x_ff) * MUL_W'(recip);

   always_ff @(posedge clock) begin
      if (load[0]) prod_ff <= prod_in;
      if (load[1]) begin
         q0_ff    <= q0_in;
         prod2_ff <= prod_ff;
      end
      if (load[2]) begin
         rem_ff <= rem_in;
         q0b_ff <= q0_ff;
      end
      if (load[3]) x_ff   <= x_in;
      if (load[4]) mul_ff <= mul_in;
   end

   assign scaled = mul_ff;

endmodule

`default_nettype wire

### rtl/ordered_dither_rgb_multilevel.sv
`default_nettype none

// channel   dir   handshake          payload
// req_bus   in    valid / ready      red_in, green_in, blue_in, frame_start, line_end
// rsp_bus   out   valid / ready      red_out, green_out, blue_out
// csr       in    csr_wr_en          csr_index, csr_data
//
// one pixel a clock while the output is not stalled and no divide is running;
// a result passes through 5 lane stages and the output register
// after reset and after each levels write a serial divider forms 1/(levels-1),
// one bit a cycle; no request is taken while it runs
// a stalled output holds its result; earlier stages keep filling until the pipe is full

module ordered_dither_rgb_multilevel
   import odrm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   odrm_req_if.sink                    req_bus,
   odrm_rsp_if.source                  rsp_bus
);

   localparam int NUM_LANES = 3;

   logic [SIZE_W-1:0]      matrix_size_ff;
   logic [LEVELS_W-1:0]    levels_ff;
   logic                   start_ff;
   logic [PHASE_W-1:0]     col_ff, col_in;
   logic [PHASE_W-1:0]     row_ff, row_in;
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   odrm_ctl_type           ctl_ff [CTL_STAGES];
   odrm_ctl_type           ctl_in;
   logic [PIX_W-1:0]       out_ff [NUM_LANES];

   logic [SIZE_W-1:0]      n;
   logic [LEVELS_W-1:0]    lv;
   logic [LEVELS_W-1:0]    top_level;
   logic                   busy;
   logic [RECIP_W-1:0]     recip;
   logic [PIPE_STAGES-1:0] stage_rdy;
   logic [PIPE_STAGES-1:0] stage_fill;
   logic                   accept;
   logic [PHASE_W-1:0]     col, row;
   logic [ENTRY_W-1:0]     t;
   logic [THR_W-1:0]       odd_t;
   logic [PIX_W-1:0]       pix [NUM_LANES];
   logic [MUL_W-1:0]       scaled [NUM_LANES];

   assign n         = odrm_side(matrix_size_ff);
   assign lv        = (levels_ff < LEVELS_W'(2)) ? LEVELS_W'(2) : levels_ff;
   assign top_level = lv - LEVELS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff <= SIZE_W'(4);
         levels_ff      <= LEVELS_W'(2);
         start_ff       <= 1'b1;
      end else begin
         start_ff <= 1'b0;
         if (csr_wr_en) begin
            unique case (odrm_csr_type'(csr_index))
               CSR_MATRIX_SIZE: matrix_size_ff <= csr_data[SIZE_W-1:0];
               CSR_LEVELS: begin
                  levels_ff <= csr_data[LEVELS_W-1:0];
                  start_ff  <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   odrm_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .divisor (top_level),
      .busy    (busy),
      .recip   (recip)
   );

   // a stage loads when it is empty or its content moves on
   always_comb begin
      stage_rdy[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_bus.ready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      stage_fill[0] = req_bus.valid && !busy;
      for (int k = 1; k < PIPE_STAGES; k++) begin
         stage_fill[k] = valid_ff[k-1];
      end
      for (int k = 0; k < PIPE_STAGES; k++) begin
         valid_in[k] = stage_rdy[k] ? stage_fill[k] : valid_ff[k];
      end
   end

   assign req_bus.ready = stage_rdy[0] && !busy;
   assign accept        = req_bus.valid && req_bus.ready;

   // phases, reduced in case the size changed since they were stored
   assign col = req_bus.frame_start ? '0 : odrm_wrap(col_ff, n);
   assign row = req_bus.frame_start ? '0 : odrm_wrap(row_ff, n);
   assign t   = odrm_entry(n, row, col);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (req_bus.line_end) begin
            col_in = '0;
            row_in = (row + PHASE_W'(1) == n) ? '0 : row + PHASE_W'(1);
         end else begin
            col_in = (col + PHASE_W'(1) == n) ? '0 : col + PHASE_W'(1);
            row_in = row;
         end
      end
   end

   assign odd_t       = {(THR_W-1)'(t), 1'b1};
   assign ctl_in.thr  = (odd_t << 8) - odd_t;
   assign ctl_in.nsq2 = odrm_nsq2(n);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) ctl_ff[0] <= ctl_in;
      for (int k = 1; k < CTL_STAGES; k++) begin
         if (stage_rdy[k]) ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   assign pix[0] = req_bus.red_in;
   assign pix[1] = req_bus.green_in;
   assign pix[2] = req_bus.blue_in;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      odrm_lane u_lane (
         .clock     (clock),
         .load      (stage_rdy[LANE_STAGES-1:0]),
         .value     (pix[i]),
         .lv        (lv),
         .top_level (top_level),
         .recip     (recip),
         .ctl       (ctl_ff[CTL_STAGES-1]),
         .scaled    (scaled[i])
      );
   end

   // merge the three lanes into the result register
   always_ff @(posedge clock) begin
      if (stage_rdy[PIPE_STAGES-1]) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            out_ff[i] <= scaled[i][RECIP_SHIFT +: PIX_W];
         end
      end
   end

   assign rsp_bus.valid     = valid_ff[PIPE_STAGES-1];
   assign rsp_bus.red_out   = out_ff[0];
   assign rsp_bus.green_out = out_ff[1];
   assign rsp_bus.blue_out  = out_ff[2];

endmodule

`default_nettype wire

### tb/sv/ordered_dither_rgb_multilevel_test.sv
`timescale 1ns / 1ps

module ordered_dither_rgb_multilevel_test;
   import odrm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_start;
      logic       line_end;
   } pixel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   localparam int unsigned BAYER2[4]  = '{0, 2, 3, 1};
   localparam int unsigned BAYER3[9]  = '{6, 8, 4, 1, 0, 3, 5, 2, 7};
   localparam int unsigned BAYER4[16] = '{0, 8, 2, 10, 12, 4, 14, 6,
                                          3, 11, 1, 9, 15, 7, 13, 5};
   localparam int unsigned BAYER6[36] = '{0, 32, 8, 40, 2, 34,
                                          48, 16, 56, 24, 50, 18,
                                          12, 44, 4, 36, 14, 46,
                                          60, 28, 52, 20, 62, 30,
                                          3, 35, 11, 43, 1, 33,
                                          51, 19, 59, 27, 49, 17};

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   odrm_req_if req_bus ();
   odrm_rsp_if rsp_bus ();

   ordered_dither_rgb_multilevel dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // testbench copy of the block's configuration and raster phases
   logic [SIZE_W-1:0]   cfg_size = 3'd4;
   logic [LEVELS_W-1:0] cfg_levels = 9'd2;
   int unsigned         column_phase = 0;
   int unsigned         row_phase = 0;

   pixel_type pending_pixels[$];
   rgb_type   expected_pixels[$];

   int idle_pct = 28;
   int mismatches = 0;
   int pixels_taken = 0;
   int results_seen = 0;
   int settings_used = 0;
   int cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic int unsigned threshold(input int unsigned n, row, col);
      int unsigned k;
      k = row * n + col;
      case (n)
         3: return BAYER3[k % 9];
         4: return BAYER4[k % 16];
         6: return BAYER6[k % 36];
         default: return BAYER2[k % 4];
      endcase
   endfunction

   function automatic logic [7:0] quantise(input int unsigned v, lv, n, t);
      int unsigned prod, q, rem;
      prod = v * lv;
      q = prod / 255;
      rem = prod % 255;
      if (rem * 2 * n * n > 255 * (2 * t + 1)) q++;
      if (q > lv - 1) q = lv - 1;
      return 8'((q * 255) / (lv - 1));
   endfunction

   // works out one dithered pixel and moves the raster phases on
   function automatic rgb_type dither_pixel(input pixel_type px);
      int unsigned n, lv, col, row, t;
      rgb_type o;
      n = (cfg_size == 3'd3 || cfg_size == 3'd4 || cfg_size == 3'd6) ? cfg_size : 2;
      lv = (cfg_levels < 2) ? 2 : cfg_levels;
      if (px.frame_start) begin
         column_phase = 0;
         row_phase = 0;
      end
      // a phase left over from a bigger size is folded back first
      col = column_phase % n;
      row = row_phase % n;
      t = threshold(n, row, col);
      o.red = quantise(px.red, lv, n, t);
      o.green = quantise(px.green, lv, n, t);
      o.blue = quantise(px.blue, lv, n, t);
      if (px.line_end) begin
         column_phase = 0;
         row_phase = (row + 1) % n;
      end else begin
         column_phase = (col + 1) % n;
         row_phase = row;
      end
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin : drive
      pixel_type px;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            px = '{req_bus.red_in, req_bus.green_in, req_bus.blue_in,
                   req_bus.frame_start, req_bus.line_end};
            expected_pixels.push_back(dither_pixel(px));
            pixels_taken++;
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
               px = pending_pixels.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.red_in <= px.red;
               req_bus.green_in <= px.green;
               req_bus.blue_in <= px.blue;
               req_bus.frame_start <= px.frame_start;
               req_bus.line_end <= px.line_end;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : watch
      rgb_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result %0d/%0d/%0d with nothing expected",
                                         rsp_bus.red_out, rsp_bus.green_out,
                                         rsp_bus.blue_out));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_bus.red_out !== want.red)
                  report_mismatch($sformatf("red got %0d expected %0d",
                                            rsp_bus.red_out, want.red));
               if (rsp_bus.green_out !== want.green)
                  report_mismatch($sformatf("green got %0d expected %0d",
                                            rsp_bus.green_out, want.green));
               if (rsp_bus.blue_out !== want.blue)
                  report_mismatch($sformatf("blue got %0d expected %0d",
                                            rsp_bus.blue_out, want.blue));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[ordered_dither_rgb_multilevel] ERROR");
         $finish;
      end
   end

   task automatic push_pixel(input logic [7:0] r, g, b, input logic fs, le);
      pending_pixels.push_back('{r, g, b, fs, le});
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(1, 8));
         default: return 8'($urandom);
      endcase
   endfunction

   // wait until every request has gone in and every result has come out
   task automatic settle();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_bus.valid || expected_pixels.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input odrm_csr_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MATRIX_SIZE) cfg_size = val[SIZE_W-1:0];
      else cfg_levels = val[LEVELS_W-1:0];
   endtask

   task automatic set_config(input logic [SIZE_W-1:0] size, input logic [LEVELS_W-1:0] lv);
      // upper data bits carry junk on a size write; only the low bits count
      write_csr(CSR_MATRIX_SIZE, {6'($urandom), size});
      write_csr(CSR_LEVELS, lv);
      settings_used++;
      @(negedge clock);
   endtask

   // mostly whole frames with random content, some stray marks in between
   task automatic queue_pixels(input int count, input bit resume);
      int made, w, h, k;
      bit first;
      made = 0;
      first = 1'b1;
      while (made < count) begin
         if ($urandom_range(99) < 80) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            for (int y = 0; y < h; y++) begin
               for (int x = 0; x < w; x++) begin
                  push_pixel(pick_channel(), pick_channel(), pick_channel(),
                             x == 0 && y == 0 && !(first && resume), x == w - 1);
                  made++;
               end
            end
         end else begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) begin
               push_pixel(pick_channel(), pick_channel(), pick_channel(),
                          $urandom_range(99) < 15, $urandom_range(99) < 30);
               made++;
            end
         end
         first = 1'b0;
      end
   endtask

   initial begin : stimulus
      logic [SIZE_W-1:0]   size;
      logic [LEVELS_W-1:0] lv;
      logic [LEVELS_W-1:0] level_extremes[8];
      level_extremes = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd255, 9'd256, 9'd257, 9'd511};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_MATRIX_SIZE;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // settings out of reset, channel extremes
      push_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
      push_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
      push_pixel(8'd1, 8'd128, 8'd254, 1'b0, 1'b0);
      push_pixel(8'd254, 8'd127, 8'd2, 1'b0, 1'b1);
      push_pixel(8'h55, 8'hAA, 8'h0F, 1'b0, 1'b0);
      push_pixel(8'hF0, 8'h33, 8'hCC, 1'b0, 1'b1);
      settle();

      // walk the first five columns of the 6x6 matrix
      set_config(3'd6, 9'd256);
      push_pixel(8'd255, 8'd0, 8'd200, 1'b1, 1'b0);
      for (int i = 0; i < 4; i++)
         push_pixel(8'(60 * i + 3), 8'(255 - 50 * i), 8'd129, 1'b0, 1'b0);
      settle();

      // size shrinks mid-frame, too few levels
      set_config(3'd3, 9'd1);
      push_pixel(8'd128, 8'd127, 8'd255, 1'b0, 1'b0);
      push_pixel(8'd64, 8'd191, 8'd0, 1'b0, 1'b1);
      push_pixel(8'd200, 8'd100, 8'd50, 1'b0, 1'b0);
      push_pixel(8'd255, 8'd1, 8'd254, 1'b0, 1'b0);
      settle();

      // unsupported sizes, levels at the top of the range and at zero
      set_config(3'd7, 9'd511);
      push_pixel(8'd255, 8'd254, 8'd1, 1'b0, 1'b0);
      push_pixel(8'd0, 8'd128, 8'd255, 1'b0, 1'b1);
      push_pixel(8'd77, 8'd178, 8'd33, 1'b0, 1'b0);
      settle();
      set_config(3'd0, 9'd0);
      push_pixel(8'd255, 8'd128, 8'd127, 1'b1, 1'b0);
      push_pixel(8'd0, 8'd1, 8'd254, 1'b0, 1'b0);
      push_pixel(8'd90, 8'd170, 8'd255, 1'b0, 1'b1);
      settle();

      for (int ph = 0; ph < 20; ph++) begin
         if (ph < 8) begin
            size = 3'(ph);
            lv = level_extremes[ph];
         end else begin
            size = 3'($urandom_range(0, 7));
            case ($urandom_range(3))
               0: lv = 9'($urandom_range(2, 8));
               1: lv = 9'($urandom_range(9, 64));
               2: lv = 9'($urandom_range(65, 511));
               default: lv = 9'($urandom_range(0, 511));
            endcase
         end
         // a few settings run flat out on both sides
         idle_pct = (ph >= 8 && ph < 11) ? 0 : 28;
         set_config(size, lv);
         queue_pixels(20, $urandom_range(3) == 0);
         settle();
      end

      $display("covered %0d pixels and %0d results over %0d size and level settings",
               pixels_taken, results_seen, settings_used);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("[ordered_dither_rgb_multilevel] OK");
      end else begin
         $display("[ordered_dither_rgb_multilevel] ERROR");
      end
      $finish;
   end

endmodule
